FILE: src/awpw_pkg.sv
// ============================================================================
// awpw_pkg
// Shared types and constants for the address window pixel writer.
// ============================================================================
`default_nettype none

package awpw_pkg;

  localparam int GAME_WIDTH_DEF  = 128;
  localparam int GAME_HEIGHT_DEF = 128;
  localparam int ROW_PITCH_DEF   = 160;

  localparam int FieldW  = 16;
  localparam int CoordW  = 18;
  localparam int LeftW   = 17;
  localparam int IndexW  = 15;
  localparam int ColorW  = 15;
  localparam int ChanW   = 5;

  localparam int RedLsb   = 11;
  localparam int GreenLsb = 6;
  localparam int BlueLsb  = 10;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [LeftW-1:0]  left_t;
  typedef logic signed [FieldW-1:0] field_t;
  typedef logic [IndexW-1:0]        index_t;
  typedef logic [ColorW-1:0]        color_t;
  typedef logic [FieldW-1:0]        pixel_t;

  localparam coord_t ROW_MAX = coord_t'(131071);

  typedef enum logic {
    KIND_WINDOW = 1'b0,
    KIND_PIXEL  = 1'b1
  } kind_t;

  typedef struct packed {
    field_t x;
    field_t y;
    field_t width;
    field_t height;
  } win_t;

  typedef struct packed {
    logic   write_enable;
    index_t pixel_index;
  } pix_res_t;

endpackage

`default_nettype wire

FILE: src/awpw_in_if.sv
// ============================================================================
// awpw_in_if
// Request channel carrying set-window and pixel requests.
// ============================================================================
`default_nettype none

interface awpw_in_if;
  import awpw_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  field_t x;
  field_t y;
  field_t width;
  field_t height;
  pixel_t pixel_value;
  logic   keep_order;
  logic   burst_end;

  modport source (
    output valid, kind, x, y, width, height, pixel_value, keep_order, burst_end,
    input  ready
  );

  modport sink (
    input  valid, kind, x, y, width, height, pixel_value, keep_order, burst_end,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/awpw_out_if.sv
// ============================================================================
// awpw_out_if
// Result channel carrying one bitmap write per pixel request.
// ============================================================================
`default_nettype none

interface awpw_out_if;
  import awpw_pkg::*;

  logic   valid;
  logic   ready;
  logic   write_enable;
  logic   page;
  index_t pixel_index;
  color_t bgr_color;
  logic   burst_done;

  modport source (
    output valid, write_enable, page, pixel_index, bgr_color, burst_done,
    input  ready
  );

  modport sink (
    input  valid, write_enable, page, pixel_index, bgr_color, burst_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/address_window_pixel_writer_top.sv
// ============================================================================
// address_window_pixel_writer_top
// Display address window with a cursor that turns pixel requests into writes.
// ============================================================================
// Every request is taken into an input register and handled from there:
// a set-window request updates the window and cursor, a pixel request reads the
// cursor, steps it and loads one bitmap write into the output register. The
// block takes one request per cycle for as long as the result side is ready,
// and each write is offered from the output register; the combinational
// cursor compare and increment sets that rate. The draw page may be written
// only while no request is in flight.
`default_nettype none

module address_window_pixel_writer_top #(
  parameter int GAME_WIDTH  = awpw_pkg::GAME_WIDTH_DEF,
  parameter int GAME_HEIGHT = awpw_pkg::GAME_HEIGHT_DEF,
  parameter int ROW_PITCH   = awpw_pkg::ROW_PITCH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  awpw_in_if.sink    in_ch,
  awpw_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import awpw_pkg::*;

  logic     draw_page_r;
  logic     in_valid_r,  in_valid_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic     in_kind_r;
  win_t     in_win_r;
  pixel_t   in_pixel_r;
  logic     in_keep_r;
  logic     in_burst_r;

  logic     out_we_r;
  logic     out_page_r;
  index_t   out_index_r;
  color_t   out_color_r;
  logic     out_burst_r;

  logic     accept;
  logic     adv;
  logic     is_pixel;
  logic     out_load;
  pix_res_t res;
  color_t   color;

  assign is_pixel = (in_kind_r == KIND_PIXEL);
  assign adv      = in_valid_r && (!is_pixel || !out_valid_r || out_ch.ready);
  assign out_load = adv && is_pixel;
  assign in_ch.ready = !in_valid_r || adv;
  assign accept   = in_ch.valid && in_ch.ready;

  awpw_cursor #(
    .GAME_WIDTH  (GAME_WIDTH),
    .GAME_HEIGHT (GAME_HEIGHT),
    .ROW_PITCH   (ROW_PITCH)
  ) u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .win_load (adv && !is_pixel),
    .win      (in_win_r),
    .pix_step (out_load),
    .res      (res)
  );

  awpw_color u_color (
    .pixel_value (in_pixel_r),
    .keep_order  (in_keep_r),
    .bgr_color   (color)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_page_r <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        draw_page_r <= cfg_wdata;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind_r         <= in_ch.kind;
      in_win_r.x        <= in_ch.x;
      in_win_r.y        <= in_ch.y;
      in_win_r.width    <= in_ch.width;
      in_win_r.height   <= in_ch.height;
      in_pixel_r        <= in_ch.pixel_value;
      in_keep_r         <= in_ch.keep_order;
      in_burst_r        <= in_ch.burst_end;
    end
    if (out_load) begin
      out_we_r    <= res.write_enable;
      out_page_r  <= draw_page_r;
      out_index_r <= res.pixel_index;
      out_color_r <= color;
      out_burst_r <= in_burst_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.page         = out_page_r;
  assign out_ch.pixel_index  = out_index_r;
  assign out_ch.bgr_color    = out_color_r;
  assign out_ch.burst_done   = out_burst_r;

`ifndef SYNTH
  a_window_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !is_pixel) |=> (out_valid_r == $past(out_valid_r && !out_ch.ready)))
    else $error("set-window request changed the result register");

  a_pixel_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("pixel request did not produce a write");

  a_outside_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_we_r) |-> (out_index_r == '0))
    else $error("disabled write carries a nonzero pixel index");
`endif

endmodule

`default_nettype wire

FILE: src/awpw_color.sv
// ============================================================================
// awpw_color
// Optional byte swap and RGB565 to BGR555 conversion.
// ============================================================================
`default_nettype none

module awpw_color (
  input  awpw_pkg::pixel_t pixel_value,
  input  logic             keep_order,
  output awpw_pkg::color_t bgr_color
);
  import awpw_pkg::*;

  pixel_t           pix;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  assign pix   = keep_order ? pixel_value : {pixel_value[7:0], pixel_value[15:8]};
  assign red   = pix[RedLsb +: ChanW];
  assign green = pix[GreenLsb +: ChanW];
  assign blue  = pix[ChanW-1:0];

  // Blue lands in the top field, red in the bottom one.
  assign bgr_color = {blue, green, red};

endmodule

`default_nettype wire

FILE: src/awpw_cursor.sv
// ============================================================================
// awpw_cursor
// Window edges and write cursor, with the bounds check and pixel address.
// ============================================================================
`default_nettype none

module awpw_cursor #(
  parameter int GAME_WIDTH  = awpw_pkg::GAME_WIDTH_DEF,
  parameter int GAME_HEIGHT = awpw_pkg::GAME_HEIGHT_DEF,
  parameter int ROW_PITCH   = awpw_pkg::ROW_PITCH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               win_load,
  input  awpw_pkg::win_t     win,
  input  logic               pix_step,
  output awpw_pkg::pix_res_t res
);
  import awpw_pkg::*;

  localparam int RowW = $clog2(GAME_HEIGHT + 1);
  localparam int ColW = $clog2(GAME_WIDTH + 1);

  left_t  left_edge_r,  left_edge_nxt;
  coord_t right_edge_r, right_edge_nxt;
  coord_t cursor_col_r, cursor_col_nxt;
  coord_t cursor_row_r, cursor_row_nxt;

  logic   win_ok;
  logic   in_area;
  coord_t col_inc;

  assign win_ok = (win.width > 0) && (win.height > 0);

  assign in_area = !cursor_col_r[CoordW-1] && (cursor_col_r < coord_t'(GAME_WIDTH)) &&
                   !cursor_row_r[CoordW-1] && (cursor_row_r < coord_t'(GAME_HEIGHT));

  assign col_inc = cursor_col_r + coord_t'(1);

  always_comb begin
    res.write_enable = in_area;
    res.pixel_index  = '0;
    if (in_area) begin
      res.pixel_index = IndexW'(cursor_row_r[RowW-1:0]) * IndexW'(ROW_PITCH)
                      + IndexW'(cursor_col_r[ColW-1:0]);
    end
  end

  always_comb begin
    left_edge_nxt  = left_edge_r;
    right_edge_nxt = right_edge_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    if (win_load && win_ok) begin
      left_edge_nxt  = LeftW'(win.x);
      right_edge_nxt = CoordW'(win.x) + CoordW'(win.width) - coord_t'(1);
      cursor_col_nxt = CoordW'(win.x);
      cursor_row_nxt = CoordW'(win.y);
    end else if (pix_step) begin
      if (col_inc > right_edge_r) begin
        cursor_col_nxt = CoordW'(left_edge_r);
        if (cursor_row_r < ROW_MAX) begin
          cursor_row_nxt = cursor_row_r + coord_t'(1);
        end
      end else begin
        cursor_col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_edge_r  <= '0;
      right_edge_r <= '1;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      left_edge_r  <= left_edge_nxt;
      right_edge_r <= right_edge_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: verif/address_window_pixel_writer_top_tb.sv
// ============================================================================
// address_window_pixel_writer_top_tb
// Drives set-window and pixel requests into the address window pixel writer,
// predicts every bitmap write from its own copy of the window, cursor and draw
// page, and checks the writes field by field under random idling on both sides.
// ============================================================================

module address_window_pixel_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import awpw_pkg::*;

  localparam int GameW       = GAME_WIDTH_DEF;
  localparam int GameH       = GAME_HEIGHT_DEF;
  localparam int Pitch       = ROW_PITCH_DEF;
  localparam int RowLimit    = 131071;
  localparam int StallLimit  = 1000;
  localparam int SettleTicks = 4;
  localparam int RandomItems = 760;
  localparam int DeepPixels  = 40;

  typedef struct packed {
    kind_t  kind;
    field_t x;
    field_t y;
    field_t width;
    field_t height;
    pixel_t pixel_value;
    logic   keep_order;
    logic   burst_end;
  } pixel_request_t;

  typedef struct packed {
    logic   write_enable;
    logic   page;
    index_t pixel_index;
    color_t bgr_color;
    logic   burst_done;
  } pixel_write_t;

  class bitmap_write_board;
    bit           draw_page;
    int           window_left;
    int           window_right;
    int           cursor_col;
    int           cursor_row;
    int           mismatches;
    pixel_write_t expected_writes[$];

    function new();
      draw_page    = 1'b0;
      window_left  = 0;
      window_right = -1;
      cursor_col   = 0;
      cursor_row   = 0;
      mismatches   = 0;
    endfunction

    function void note_request(pixel_request_t r);
      pixel_t       pix;
      bit           in_area;
      pixel_write_t w;
      if (r.kind == KIND_WINDOW) begin
        if (r.width > 0 && r.height > 0) begin
          window_left  = int'(r.x);
          window_right = int'(r.x) + int'(r.width) - 1;
          cursor_col   = int'(r.x);
          cursor_row   = int'(r.y);
        end
        return;
      end
      pix = r.keep_order ? r.pixel_value : {r.pixel_value[7:0], r.pixel_value[15:8]};
      in_area = cursor_col >= 0 && cursor_col < GameW && cursor_row >= 0 && cursor_row < GameH;
      w.write_enable = in_area;
      w.page         = draw_page;
      w.pixel_index  = in_area ? index_t'(cursor_row * Pitch + cursor_col) : '0;
      w.bgr_color    = {pix[4:0], pix[10:6], pix[15:11]};
      w.burst_done   = r.burst_end;
      expected_writes.push_back(w);
      cursor_col++;
      if (cursor_col > window_right) begin
        cursor_col = window_left;
        if (cursor_row < RowLimit) begin
          cursor_row++;
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_write(pixel_write_t got);
      pixel_write_t want;
      if (expected_writes.size() == 0) begin
        $display("%0t: write with none expected, actual we=%0d page=%0d index=%0d color=0x%0h",
                 $time, got.write_enable, got.page, got.pixel_index, got.bgr_color);
        mismatches++;
        return;
      end
      want = expected_writes.pop_front();
      compare_field("write_enable", want.write_enable, got.write_enable);
      compare_field("page", want.page, got.page);
      compare_field("pixel_index", want.pixel_index, got.pixel_index);
      compare_field("bgr_color", want.bgr_color, got.bgr_color);
      compare_field("burst_done", want.burst_done, got.burst_done);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   steady;
  int   idle_cycles = 0;

  awpw_in_if  in_ch();
  awpw_out_if out_ch();

  bitmap_write_board board = new();

  address_window_pixel_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_request_t window_req(int x, int y, int w, int h);
    pixel_request_t r;
    r             = pixel_request_t'({$urandom(), $urandom(), $urandom()});
    r.kind        = KIND_WINDOW;
    r.x           = field_t'(x);
    r.y           = field_t'(y);
    r.width       = field_t'(w);
    r.height      = field_t'(h);
    return r;
  endfunction

  function automatic pixel_request_t pixel_req(int unsigned pix, bit keep, bit last);
    pixel_request_t r;
    r             = pixel_request_t'({$urandom(), $urandom(), $urandom()});
    r.kind        = KIND_PIXEL;
    r.pixel_value = pixel_t'(pix);
    r.keep_order  = keep;
    r.burst_end   = last;
    return r;
  endfunction

  function automatic pixel_request_t random_window();
    if ($urandom_range(0, 9) == 0) begin
      return window_req($urandom(), $urandom(), $urandom_range(1, 32767),
                        $urandom_range(1, 32767));
    end
    return window_req(int'($urandom_range(0, 150)) - 10, int'($urandom_range(0, 150)) - 10,
                      $urandom_range(0, 3) == 0 ? $urandom_range(1, 200) : $urandom_range(1, 40),
                      $urandom_range(1, 20));
  endfunction

  task automatic send(pixel_request_t r);
    int g;
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= r.kind;
    in_ch.x           <= r.x;
    in_ch.y           <= r.y;
    in_ch.width       <= r.width;
    in_ch.height      <= r.height;
    in_ch.pixel_value <= r.pixel_value;
    in_ch.keep_order  <= r.keep_order;
    in_ch.burst_end   <= r.burst_end;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(r);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.expected_writes.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic write_page(bit value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.draw_page = value;
  endtask

  task automatic random_phase(int target);
    pixel_request_t r;
    int             n;
    int             burst;
    n = 0;
    while (n < target) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        send(random_window());
        n++;
        burst = $urandom_range(1, 48);
        for (int i = 0; i < burst; i++) begin
          send(pixel_req($urandom(), $urandom_range(0, 1), i == burst - 1));
          n++;
        end
      end else begin
        r = pixel_request_t'({$urandom(), $urandom(), $urandom()});
        send(r);
        if (r.kind == KIND_PIXEL || (r.width > 0 && r.height > 0)) n++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    int unsigned pix;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    steady            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_WINDOW;
    in_ch.x           <= '0;
    in_ch.y           <= '0;
    in_ch.width       <= '0;
    in_ch.height      <= '0;
    in_ch.pixel_value <= '0;
    in_ch.keep_order  <= 1'b0;
    in_ch.burst_end   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_page(1'b1);
    send(pixel_req(16'hFFFF, 1'b1, 1'b0));
    send(pixel_req(16'h0000, 1'b0, 1'b0));
    send(pixel_req(16'h00FF, 1'b0, 1'b1));
    send(window_req(10, 10, 0, 5));
    send(window_req(10, 10, 5, -1));
    send(window_req(-32768, 0, -32768, 32767));
    send(pixel_req(16'hF800, 1'b1, 1'b1));
    send(window_req(126, 126, 4, 2));
    for (int i = 0; i < 10; i++) begin
      pix = (i % 3 == 0) ? 16'h07E0 : (i % 3 == 1) ? 16'h001F : 16'hE007;
      send(pixel_req(pix, i % 2, i == 9));
    end
    send(window_req(-32768, -32768, 32767, 32767));
    send(pixel_req(16'h8001, 1'b1, 1'b1));
    send(window_req(32767, 32767, 32767, 1));
    send(pixel_req(16'h7FFE, 1'b0, 1'b1));
    send(window_req(0, 0, 1, 1));
    send(pixel_req(16'hAAAA, 1'b1, 1'b0));
    send(pixel_req(16'h5555, 1'b0, 1'b1));
    settle();

    write_page(1'b0);
    random_phase(RandomItems / 2);
    settle();

    write_page(1'b1);
    random_phase(RandomItems - RandomItems / 2);
    settle();

    // A one-column window far down the rows walks the cursor further down,
    // outside the game area, then a fresh window must recover.
    write_page(1'b0);
    steady = 1'b1;
    send(window_req(3, 32767, 1, 1));
    for (int i = 0; i < DeepPixels; i++) begin
      send(pixel_req($urandom(), $urandom_range(0, 1), 1'b0));
    end
    send(window_req(0, 0, 8, 2));
    for (int i = 0; i < 16; i++) begin
      send(pixel_req($urandom(), $urandom_range(0, 1), i == 15));
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    while (board.expected_writes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int run;
    int g;
    out_ch.ready <= 1'b0;
    forever begin
      run = steady ? 16 : $urandom_range(1, 24);
      repeat (run) begin
        @(posedge clk);
        out_ch.ready <= 1'b1;
      end
      g = gap_len();
      repeat (g) begin
        @(posedge clk);
        out_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : write_monitor
    pixel_write_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.write_enable = out_ch.write_enable;
      got.page         = out_ch.page;
      got.pixel_index  = out_ch.pixel_index;
      got.bgr_color    = out_ch.bgr_color;
      got.burst_done   = out_ch.burst_done;
      board.check_write(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
